### rtl/assert_macros.svh
// assertion helpers shared by the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VNL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define VNL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/vnl_pkg.sv
// ----------------------------------------------------------------------------
// vnl_pkg
// shared widths for the vec4 nlerp and normalise datapath
// ----------------------------------------------------------------------------
`default_nettype none

package vnl_pkg;
    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;
    localparam int BLEND_WIDTH     = 15;
endpackage

`default_nettype wire

### rtl/vec4_nlerp_normalize.sv
// ----------------------------------------------------------------------------
// vec4_nlerp_normalize
// normalised linear interpolation of two signed fixed-point vec4 values
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one request per accepted beat: a and b vectors and blend
//   m_* channel returns the unit vector, the floor root of the squared length
//   and, in m_tuser, a flag set when the blended vector is all zero
//   a request passes through the lanes, the merge register, the root and
//   divider pipelines and the result register, in that order
//   throughput is one request per cycle while no result is held; four lanes
//   blend and divide side by side, one shared root pipeline takes the merged squared length
//   the whole pipeline advances together; when the result register holds a
//   result that is not taken, s_tready falls and every stage holds
//   reset clears all valid flags; no result is shown until a new request
//   has gone through the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_nlerp_normalize #(
    parameter int COMPONENT_WIDTH = vnl_pkg::COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = vnl_pkg::FRACTION_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_tvalid,
    output logic        s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend, zero fill
    input  wire logic [((8*COMPONENT_WIDTH+vnl_pkg::BLEND_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    // unit_x, unit_y, unit_z, unit_w, magnitude, zero fill
    output logic [((5*COMPONENT_WIDTH+1+7)/8)*8-1:0] m_tdata,
    // zero_length
    output logic        m_tuser
);
    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int BW  = vnl_pkg::BLEND_WIDTH;
    localparam int RW  = W + 1;
    localparam int OW  = ((5*W+1+7)/8)*8;
    localparam int LAT = 3 + 1 + RW + (F + 1) + 1;

    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic signed [W-1:0] c_lane  [4];
    logic [2*W-1:0]      sq_lane [4];
    logic [2*W+1:0]      sum_reg;
    logic [W:0]          root;
    logic signed [W-1:0] c_dly_reg [RW+1][4];
    logic [W-1:0]        unit_lane [4];
    logic [W:0]          len_lane  [4];
    logic [OW-1:0]       tdata_reg;
    logic                zero_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        vnl_lane #(.W(W), .F(F)) u_lane (
            .clk    (clk),
            .en     (adv),
            .a      (s_tdata[i*W +: W]),
            .b      (s_tdata[(i+4)*W +: W]),
            .blend  (s_tdata[8*W +: BW]),
            .c_out  (c_lane[i]),
            .sq_out (sq_lane[i])
        );
    end

    // merge the four squares and keep the components alongside the root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= (2*W+2)'(sq_lane[0]) + (2*W+2)'(sq_lane[1])
                     + (2*W+2)'(sq_lane[2]) + (2*W+2)'(sq_lane[3]);
            c_dly_reg[0] <= c_lane;
            for (int k = 1; k < RW + 1; k++)
                c_dly_reg[k] <= c_dly_reg[k-1];
        end
    end

    vnl_isqrt #(.W(W)) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sum_reg),
        .root (root)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        logic signed [W-1:0] cv;
        logic [W-1:0]        mag;

        assign cv  = c_dly_reg[RW][i];
        assign mag = cv[W-1] ? W'(-cv) : W'(cv);

        vnl_div #(.W(W), .F(F)) u_div (
            .clk     (clk),
            .en      (adv),
            .mag_in  (mag),
            .neg_in  (cv[W-1]),
            .len_in  (root),
            .unit    (unit_lane[i]),
            .len_out (len_lane[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= OW'({len_lane[0], unit_lane[3], unit_lane[2],
                              unit_lane[1], unit_lane[0]});
            zero_reg  <= (len_lane[0] == '0);
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = tdata_reg;
    assign m_tuser  = zero_reg;
endmodule

`default_nettype wire

### rtl/vnl_lane.sv
// ----------------------------------------------------------------------------
// vnl_lane
// one component lane: blend, saturate and square, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module vnl_lane #(
    parameter int W = vnl_pkg::COMPONENT_WIDTH,
    parameter int F = vnl_pkg::FRACTION_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [W-1:0]               a,
    input  wire logic signed [W-1:0]               b,
    input  wire logic [vnl_pkg::BLEND_WIDTH-1:0]   blend,
    output logic signed [W-1:0]                    c_out,
    output logic [2*W-1:0]                         sq_out
);
    localparam int BW = vnl_pkg::BLEND_WIDTH;
    localparam int PW = W + BW + 2;
    localparam int SW = PW + 1;

    logic signed [W:0]      diff;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [W-1:0]    a_reg;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   lo;
    logic signed [SW-1:0]   hi;
    logic signed [W-1:0]    c_next;
    logic signed [W-1:0]    c_reg;
    logic [W-1:0]           mag;
    logic [2*W-1:0]         sq_next;
    logic [2*W-1:0]         sq_reg;
    logic signed [W-1:0]    c2_reg;

    assign diff      = (W+1)'(b) - (W+1)'(a);
    assign prod_next = PW'(diff) * PW'(signed'({1'b0, blend}));

    // arithmetic shift floors the step toward minus infinity
    assign sum = SW'(a_reg) + SW'(prod_reg >>> F);
    assign lo  = -(SW'(1) <<< (W-1));
    assign hi  = (SW'(1) <<< (W-1)) - SW'(1);

    always_comb
    begin
        priority if (sum < lo)
            c_next = lo[W-1:0];
        else if (sum > hi)
            c_next = hi[W-1:0];
        else
            c_next = sum[W-1:0];
    end

    assign mag     = c_reg[W-1] ? W'(-c_reg) : W'(c_reg);
    assign sq_next = (2*W)'(mag) * (2*W)'(mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
            c_reg    <= c_next;
            c2_reg   <= c_reg;
            sq_reg   <= sq_next;
        end
    end

    assign c_out  = c2_reg;
    assign sq_out = sq_reg;
endmodule

`default_nettype wire

### rtl/vnl_isqrt.sv
// ----------------------------------------------------------------------------
// vnl_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vnl_isqrt #(
    parameter int W = vnl_pkg::COMPONENT_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [2*W+1:0]   rad,
    output logic [W:0]            root
);
    localparam int RW  = W + 1;
    localparam int RMW = RW + 2;

    logic [2*W+1:0] rad_reg  [RW];
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        localparam int P = RW - 1 - s;
        logic [2*W+1:0] rad_in;
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [RMW+1:0] cur;
        logic [RMW+1:0] trial;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        if (s == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        assign cur   = {rem_in, rad_in[2*P+1 -: 2]};
        assign trial = (RMW+2)'({root_in, 2'b01});

        always_comb
        begin
            if (cur >= trial)
            begin
                rem_next  = RMW'(cur - trial);
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RMW'(cur);
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_in;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[RW-1];
endmodule

`default_nettype wire

### rtl/vnl_div.sv
// ----------------------------------------------------------------------------
// vnl_div
// pipelined restoring divider for one lane: (|c| << F) / length, sign restored
// ----------------------------------------------------------------------------
`default_nettype none

module vnl_div #(
    parameter int W = vnl_pkg::COMPONENT_WIDTH,
    parameter int F = vnl_pkg::FRACTION_BITS
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [W-1:0]   mag_in,
    input  wire logic           neg_in,
    input  wire logic [W:0]     len_in,
    output logic [W-1:0]        unit,
    output logic [W:0]          len_out
);
    localparam int NS  = F + 1;
    localparam int RMW = W + 2;

    logic [RMW-1:0] rem_reg [NS];
    logic [NS-1:0]  q_reg   [NS];
    logic [W:0]     len_reg [NS];
    logic           neg_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [RMW-1:0] rin;
        logic [NS-1:0]  qin;
        logic [W:0]     lin;
        logic           nin;
        logic [RMW-1:0] dvs;
        logic           qbit;

        if (s == 0)
        begin : g_first
            assign rin = RMW'(mag_in);
            assign qin = '0;
            assign lin = len_in;
            assign nin = neg_in;
        end
        else
        begin : g_rest
            assign rin = {rem_reg[s-1][RMW-2:0], 1'b0};
            assign qin = q_reg[s-1];
            assign lin = len_reg[s-1];
            assign nin = neg_reg[s-1];
        end

        assign dvs  = RMW'(lin);
        assign qbit = (rin >= dvs);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= qbit ? rin - dvs : rin;
                q_reg[s]   <= {qin[NS-2:0], qbit};
                len_reg[s] <= lin;
                neg_reg[s] <= nin;
            end
        end
    end

    logic [W+NS-1:0] qx;

    assign qx = (W+NS)'(q_reg[NS-1]);

    // zero length passes the zero vector
    always_comb
    begin
        if (len_reg[NS-1] == '0)
            unit = '0;
        else if (neg_reg[NS-1])
            unit = W'(-qx);
        else
            unit = W'(qx);
    end

    assign len_out = len_reg[NS-1];
endmodule

`default_nettype wire

### rtl/vnl_checker.sv
// ----------------------------------------------------------------------------
// vnl_checker
// port-level checks on the result channel of vec4_nlerp_normalize
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vnl_checker #(
    parameter int COMPONENT_WIDTH = vnl_pkg::COMPONENT_WIDTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_tready,
    input  wire logic   m_tvalid,
    input  wire logic   m_tready,
    input  wire logic [((5*COMPONENT_WIDTH+1+7)/8)*8-1:0] m_tdata,
    input  wire logic   m_tuser
);
    localparam int W = COMPONENT_WIDTH;

    logic mag_zero;
    logic units_zero;

    assign mag_zero   = (m_tdata[4*W +: W+1] == '0);
    assign units_zero = (m_tdata[4*W-1:0] == '0);

    // zero flag and zero magnitude agree
    `VNL_ASSERT_NOW(a_flag_mag, clk, rst_n, m_tvalid, m_tuser == mag_zero)
    // a zero vector passes through as zeros
    `VNL_ASSERT_NOW(a_zero_units, clk, rst_n, m_tvalid && m_tuser, units_zero)
    // a held result stalls the input side
    `VNL_ASSERT_NOW(a_stall_in, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    // a stalled result holds its payload
    `VNL_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind vec4_nlerp_normalize vnl_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_vnl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
